@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file refers to this package by scoped names.
package spq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int TAG_W        = 16;
    localparam int KEY_W        = 16;
    localparam int KIND_W       = 2;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DISPATCH = 2'd1,
        KIND_MODIFY   = 2'd2,
        KIND_IGNORE   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    // broadcast to every cell in the row
    typedef struct packed {
        t_cell_op           op;
        logic [TAG_W-1:0]   tag;
        logic [KEY_W-1:0]   key;
    } t_cell_cmd;

endpackage

@@ hw/rtl/spq_cmd_if.sv @@
// Command channel of the sorted priority queue: valid/ready plus command fields.
// Depends on spq_pkg.
interface spq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::KIND_W-1:0]  kind;
    logic [spq_pkg::TAG_W-1:0]   tag;
    logic [spq_pkg::KEY_W-1:0]   key;
    logic [spq_pkg::POS_W-1:0]   position;

    modport source (output valid, kind, tag, key, position, input ready);
    modport sink   (input valid, kind, tag, key, position, output ready);
endinterface

@@ hw/rtl/spq_res_if.sv @@
// Result channel of the sorted priority queue: valid/ready plus result fields.
// Depends on spq_pkg; occupancy width follows the queue capacity.
interface spq_res_if #(
    parameter int OCC_W = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
    logic                          valid;
    logic                          ready;
    logic [spq_pkg::STATUS_W-1:0]  status;
    logic [spq_pkg::TAG_W-1:0]     out_tag;
    logic [spq_pkg::KEY_W-1:0]     out_key;
    logic [OCC_W-1:0]              occupancy;

    modport source (output valid, status, out_tag, out_key, occupancy, input ready);
    modport sink   (input valid, status, out_tag, out_key, occupancy, output ready);
endinterface

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted row: holds a (tag, key) pair and shifts toward its
// neighbors on insert or remove. Depends on spq_pkg.
module spq_cell #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0,
    localparam int IW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  spq_pkg::t_cell_cmd         i_cmd,
    input  logic [IW-1:0]              i_idx,
    input  logic [CW-1:0]              i_count,
    input  logic [spq_pkg::TAG_W-1:0]  i_left_tag,
    input  logic [spq_pkg::KEY_W-1:0]  i_left_key,
    input  logic                       i_left_le,
    input  logic [spq_pkg::TAG_W-1:0]  i_right_tag,
    input  logic [spq_pkg::KEY_W-1:0]  i_right_key,
    output logic [spq_pkg::TAG_W-1:0]  o_tag,
    output logic [spq_pkg::KEY_W-1:0]  o_key,
    output logic                       o_le,
    output logic [spq_pkg::TAG_W-1:0]  o_pick_tag
);

    logic [spq_pkg::TAG_W-1:0] r_tag;
    logic [spq_pkg::KEY_W-1:0] r_key;
    logic                      w_valid;
    logic                      w_at_or_after;

    assign w_valid       = CW'(INDEX) < i_count;
    // row is sorted, so the le flags form a prefix of the occupied cells
    assign o_le          = w_valid && (r_key <= i_cmd.key);
    assign w_at_or_after = IW'(INDEX) >= i_idx;
    assign o_pick_tag    = (IW'(INDEX) == i_idx) ? r_tag : '0;
    assign o_tag         = r_tag;
    assign o_key         = r_key;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            spq_pkg::CELL_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        r_tag <= i_cmd.tag;
                        r_key <= i_cmd.key;
                    end else begin
                        r_tag <= i_left_tag;
                        r_key <= i_left_key;
                    end
                end
            end
            spq_pkg::CELL_REMOVE: begin
                if (w_at_or_after) begin
                    r_tag <= i_right_tag;
                    r_key <= i_right_key;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue: a row of CAPACITY cells kept in ascending key order.
// Insert and dispatch act on the row at once; modify removes, then re-places
// the entry through the row, and no new command is taken until it is re-placed.
// The result beat is registered and valid in the cycle after the command beat.
// Reset (i_rst_n low, synchronous) empties the queue and the result register;
// cell contents are not cleared and are only read once written.
module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    localparam int IW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int PW      = (CW > spq_pkg::POS_W) ? CW : spq_pkg::POS_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    spq_cmd_if.sink      i_cmd,
    spq_res_if.source    o_res
);

    logic [CW-1:0]                r_count;
    logic                         r_phase2;
    logic [spq_pkg::TAG_W-1:0]    r_mod_tag;
    logic [spq_pkg::KEY_W-1:0]    r_mod_key;
    logic                         r_out_valid;
    spq_pkg::t_status             r_status;
    logic [spq_pkg::TAG_W-1:0]    r_out_tag;
    logic [spq_pkg::KEY_W-1:0]    r_out_key;
    logic [CW-1:0]                r_occ;

    logic [CW-1:0]                n_count;
    logic                         n_phase2;
    logic                         n_out_valid;
    spq_pkg::t_status             n_status;
    logic [spq_pkg::TAG_W-1:0]    n_out_tag;
    logic [spq_pkg::KEY_W-1:0]    n_out_key;
    logic [CW-1:0]                n_occ;

    spq_pkg::t_cell_cmd           w_cmd;
    logic [IW-1:0]                w_idx;
    logic                         w_accept;
    logic                         w_pos_bad;
    logic [spq_pkg::POS_W-1:0]    w_pos_m1;
    logic [spq_pkg::TAG_W-1:0]    w_pick_tag;

    logic [spq_pkg::TAG_W-1:0]    w_tag  [CAPACITY];
    logic [spq_pkg::KEY_W-1:0]    w_key  [CAPACITY];
    logic                         w_le   [CAPACITY];
    logic [spq_pkg::TAG_W-1:0]    w_pick [CAPACITY];

    assign i_cmd.ready     = !r_phase2 && (!r_out_valid || o_res.ready);
    assign w_accept        = i_cmd.valid && i_cmd.ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_status;
    assign o_res.out_tag   = r_out_tag;
    assign o_res.out_key   = r_out_key;
    assign o_res.occupancy = r_occ;

    assign w_pos_bad = (i_cmd.position == '0) || (PW'(i_cmd.position) > PW'(r_count));
    assign w_pos_m1  = i_cmd.position - spq_pkg::POS_W'(1);

    always_comb begin
        w_pick_tag = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pick_tag = w_pick_tag | w_pick[i];
        end
    end

    always_comb begin
        w_cmd       = '{op: spq_pkg::CELL_HOLD, tag: i_cmd.tag, key: i_cmd.key};
        w_idx       = '0;
        n_count     = r_count;
        n_phase2    = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_out_tag   = r_out_tag;
        n_out_key   = r_out_key;
        n_occ       = r_occ;
        if (r_phase2) begin
            // second half of modify: re-place the lifted entry
            w_cmd   = '{op: spq_pkg::CELL_INSERT, tag: r_mod_tag, key: r_mod_key};
            n_count = r_count + CW'(1);
        end else if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = spq_pkg::ST_OK;
            n_out_tag   = '0;
            n_out_key   = '0;
            unique case (spq_pkg::t_kind'(i_cmd.kind))
                spq_pkg::KIND_INSERT: begin
                    if (r_count == CW'(CAPACITY)) begin
                        n_status = spq_pkg::ST_FULL;
                    end else begin
                        w_cmd.op = spq_pkg::CELL_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                spq_pkg::KIND_DISPATCH: begin
                    if (r_count == '0) begin
                        n_status = spq_pkg::ST_EMPTY;
                    end else begin
                        w_cmd.op  = spq_pkg::CELL_REMOVE;
                        n_out_tag = w_tag[0];
                        n_out_key = w_key[0];
                        n_count   = r_count - CW'(1);
                    end
                end
                spq_pkg::KIND_MODIFY: begin
                    if (w_pos_bad) begin
                        n_status = spq_pkg::ST_NOT_FOUND;
                    end else begin
                        w_cmd.op = spq_pkg::CELL_REMOVE;
                        w_idx    = IW'(w_pos_m1);
                        n_count  = r_count - CW'(1);
                        n_phase2 = 1'b1;
                    end
                end
                spq_pkg::KIND_IGNORE: begin
                end
                default: begin
                end
            endcase
            // modify ends with the same number of entries it started with
            n_occ = n_phase2 ? r_count : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_phase2    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_phase2    <= n_phase2;
            r_out_valid <= n_out_valid;
        end
        r_status  <= n_status;
        r_out_tag <= n_out_tag;
        r_out_key <= n_out_key;
        r_occ     <= n_occ;
        if (n_phase2) begin
            r_mod_tag <= w_pick_tag;
            r_mod_key <= i_cmd.key;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [spq_pkg::TAG_W-1:0] w_ltag;
        logic [spq_pkg::KEY_W-1:0] w_lkey;
        logic                      w_lle;
        logic [spq_pkg::TAG_W-1:0] w_rtag;
        logic [spq_pkg::KEY_W-1:0] w_rkey;

        if (g == 0) begin : g_first
            assign w_ltag = '0;
            assign w_lkey = '0;
            assign w_lle  = 1'b1;
        end else begin : g_mid
            assign w_ltag = w_tag[g-1];
            assign w_lkey = w_key[g-1];
            assign w_lle  = w_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_rtag = '0;
            assign w_rkey = '0;
        end else begin : g_inner
            assign w_rtag = w_tag[g+1];
            assign w_rkey = w_key[g+1];
        end

        spq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_idx       (w_idx),
            .i_count     (r_count),
            .i_left_tag  (w_ltag),
            .i_left_key  (w_lkey),
            .i_left_le   (w_lle),
            .i_right_tag (w_rtag),
            .i_right_key (w_rkey),
            .o_tag       (w_tag[g]),
            .o_key       (w_key[g]),
            .o_le        (w_le[g]),
            .o_pick_tag  (w_pick[g])
        );
    end

endmodule

@@ bench/spq_queue_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the sorted priority queue: watches both channels and predicts each beat.
// Depends on spq_pkg, spq_cmd_if and spq_res_if; exports a mismatch count and open expectations.
module spq_queue_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_cmd_if   i_cmd,
    spq_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int DEPTH      = spq_pkg::CAPACITY_DEF;
    localparam int OCC_W      = $clog2(DEPTH + 1);

    typedef struct {
        spq_pkg::t_status            status;
        logic [spq_pkg::TAG_W-1:0]   tag;
        logic [spq_pkg::KEY_W-1:0]   key;
        logic [OCC_W-1:0]            occupancy;
    } t_queue_reply;

    logic [spq_pkg::KEY_W-1:0] sorted_keys [DEPTH];
    logic [spq_pkg::TAG_W-1:0] sorted_tags [DEPTH];
    int                        held = 0;
    t_queue_reply              expected_replies [$];
    int                        mismatches = 0;
    int                        waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    // goes after every entry with key <= new key, so ties keep arrival order
    function automatic void place_sorted(input logic [spq_pkg::TAG_W-1:0] tag,
                                         input logic [spq_pkg::KEY_W-1:0] key);
        int at;
        at = 0;
        while (at < held && sorted_keys[at] <= key) at++;
        for (int i = held; i > at; i--) begin
            sorted_keys[i] = sorted_keys[i-1];
            sorted_tags[i] = sorted_tags[i-1];
        end
        sorted_keys[at] = key;
        sorted_tags[at] = tag;
        held++;
    endfunction

    function automatic void take_out(input int idx);
        for (int i = idx; i + 1 < held; i++) begin
            sorted_keys[i] = sorted_keys[i+1];
            sorted_tags[i] = sorted_tags[i+1];
        end
        held--;
    endfunction

    function automatic t_queue_reply apply_command(input logic [spq_pkg::KIND_W-1:0] kind,
                                                   input logic [spq_pkg::TAG_W-1:0]  tag,
                                                   input logic [spq_pkg::KEY_W-1:0]  key,
                                                   input logic [spq_pkg::POS_W-1:0]  pos);
        t_queue_reply              reply;
        logic [spq_pkg::TAG_W-1:0] moved_tag;
        reply.status = spq_pkg::ST_OK;
        reply.tag    = '0;
        reply.key    = '0;
        case (kind)
            spq_pkg::KIND_INSERT: begin
                if (held >= DEPTH) reply.status = spq_pkg::ST_FULL;
                else place_sorted(tag, key);
            end
            spq_pkg::KIND_DISPATCH: begin
                if (held == 0) begin
                    reply.status = spq_pkg::ST_EMPTY;
                end else begin
                    reply.tag = sorted_tags[0];
                    reply.key = sorted_keys[0];
                    take_out(0);
                end
            end
            spq_pkg::KIND_MODIFY: begin
                if (pos == 0 || int'(pos) > held) begin
                    reply.status = spq_pkg::ST_NOT_FOUND;
                end else begin
                    moved_tag = sorted_tags[int'(pos) - 1];
                    take_out(int'(pos) - 1);
                    place_sorted(moved_tag, key);
                end
            end
            default: ;
        endcase
        reply.occupancy = OCC_W'(held);
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_queue_reply want;
        if (!i_rst_n) begin
            held = 0;
            expected_replies.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, got st=%0d tag=%h key=%h occ=%0d",
                             $time, i_res.status, i_res.out_tag, i_res.out_key,
                             i_res.occupancy);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_res.status !== want.status || i_res.out_tag !== want.tag ||
                        i_res.out_key !== want.key || i_res.occupancy !== want.occupancy) begin
                        mismatches++;
                        $display("%0t: mismatch exp st=%0d tag=%h key=%h occ=%0d, %s%0d %s%h %s%h %s%0d",
                                 $time, want.status, want.tag, want.key, want.occupancy,
                                 "got st=", i_res.status, "tag=", i_res.out_tag,
                                 "key=", i_res.out_key, "occ=", i_res.occupancy);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                expected_replies.push_back(apply_command(i_cmd.kind, i_cmd.tag, i_cmd.key,
                                                         i_cmd.position));
        end
        waiting = expected_replies.size();
    end

endmodule

@@ bench/sorted_priority_queue_core_test.sv @@
`timescale 1ns / 1ps
// Top of the sorted priority queue bench: clock, reset, command stimulus, result back-pressure.
// Depends on spq_pkg, both channel interfaces, the core and spq_queue_checker.
module sorted_priority_queue_core_test;

    localparam int QUEUE_DEPTH    = spq_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 750;
    localparam int SEGMENT_LEN    = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   pressure_req;
    int   queue_depth;
    int   random_count;

    spq_cmd_if cmd_ch ();
    spq_res_if res_ch ();

    sorted_priority_queue_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    spq_queue_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [15:0] rand_key();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(0, 7));
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_tag();
        if ($urandom_range(15) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    // called right after a falling edge; returns at the falling edge after the beat
    task automatic push_command(input spq_pkg::t_kind kind, input logic [15:0] tag,
                                input logic [15:0] key, input logic [7:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.kind     <= kind;
        cmd_ch.tag      <= tag;
        cmd_ch.key      <= key;
        cmd_ch.position <= pos;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (kind == spq_pkg::KIND_INSERT && queue_depth < QUEUE_DEPTH) queue_depth++;
        if (kind == spq_pkg::KIND_DISPATCH && queue_depth > 0) queue_depth--;
        if (kind != spq_pkg::KIND_IGNORE) random_count++;
    endtask

    task automatic random_command(input int insert_pct, input int dispatch_pct);
        spq_pkg::t_kind kind;
        logic [7:0]     pos;
        int             roll;
        roll = $urandom_range(99);
        if (roll < insert_pct) kind = spq_pkg::KIND_INSERT;
        else if (roll < insert_pct + dispatch_pct) kind = spq_pkg::KIND_DISPATCH;
        else if (roll < 97) kind = spq_pkg::KIND_MODIFY;
        else kind = spq_pkg::KIND_IGNORE;
        case ($urandom_range(9))
            7:       pos = 8'd0;
            8:       pos = 8'(queue_depth + 1);
            9:       pos = 8'($urandom_range(0, 255));
            default: pos = 8'($urandom_range(1, (queue_depth > 0) ? queue_depth : 1));
        endcase
        push_command(kind, rand_tag(), rand_key(), pos);
    endtask

    task automatic pause_until_drained();
        cmd_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic run_directed();
        push_command(spq_pkg::KIND_DISPATCH, 16'h1234, 16'h5678, 8'd0);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0001, 8'd1);
        push_command(spq_pkg::KIND_IGNORE,   16'hFFFF, 16'hFFFF, 8'hFF);
        push_command(spq_pkg::KIND_INSERT,   16'hFFFF, 16'hFFFF, 8'd0);
        push_command(spq_pkg::KIND_INSERT,   16'h0000, 16'h0000, 8'hFF);
        push_command(spq_pkg::KIND_INSERT,   16'h0001, 16'h0005, 8'd0);
        push_command(spq_pkg::KIND_INSERT,   16'h0002, 16'h0005, 8'd0);
        push_command(spq_pkg::KIND_INSERT,   16'h0003, 16'h0005, 8'd0);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0009, 8'd0);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0009, 8'd6);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0009, 8'd255);
        // head to tail, lands behind the existing max key
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'hFFFF, 8'd1);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0000, 8'd5);
        push_command(spq_pkg::KIND_MODIFY,   16'h0000, 16'h0005, 8'd2);
        push_command(spq_pkg::KIND_INSERT,   16'hAAAA, 16'h0003, 8'd0);
        push_command(spq_pkg::KIND_IGNORE,   16'h0000, 16'h0000, 8'd0);
        repeat (7) push_command(spq_pkg::KIND_DISPATCH, 16'h0000, 16'h0000, 8'd0);
    endtask

    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sorted_priority_queue_core_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        int segment_left;
        int insert_pct;
        int dispatch_pct;
        int phase;
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.kind     = spq_pkg::KIND_INSERT;
        cmd_ch.tag      = '0;
        cmd_ch.key      = '0;
        cmd_ch.position = '0;
        send_idle_pct   = 16;
        recv_idle_pct   = 63;
        pressure_req    = 1'b0;
        queue_depth     = 0;
        random_count    = 0;
        segment_left    = 0;
        insert_pct      = 40;
        dispatch_pct    = 35;
        phase           = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        pause_until_drained();
        random_count = 0;

        // results blocked for a long stretch while the queue is being filled
        pressure_req <= 1'b1;
        while (queue_depth < QUEUE_DEPTH) random_command(85, 10);
        repeat (8) push_command(spq_pkg::KIND_INSERT, rand_tag(), rand_key(),
                                8'($urandom_range(0, 255)));

        while (random_count < RANDOM_ITEMS) begin
            if (phase == 0 && random_count >= RANDOM_ITEMS / 3) begin
                pause_until_drained();
                send_idle_pct = 63;
                recv_idle_pct = 16;
                phase = 1;
            end else if (phase == 1 && random_count >= 2 * RANDOM_ITEMS / 3) begin
                pause_until_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 2;
            end
            if (segment_left == 0) begin
                case ($urandom_range(2))
                    0:       begin insert_pct = 65; dispatch_pct = 15; end
                    1:       begin insert_pct = 15; dispatch_pct = 65; end
                    default: begin insert_pct = 40; dispatch_pct = 35; end
                endcase
                segment_left = SEGMENT_LEN;
            end
            segment_left--;
            random_command(insert_pct, dispatch_pct);
        end

        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("sorted_priority_queue_core_test OK");
        else
            $display("sorted_priority_queue_core_test NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/spq_pkg.sv
hw/rtl/spq_cmd_if.sv
hw/rtl/spq_res_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
bench/spq_queue_checker.sv
bench/sorted_priority_queue_core_test.sv
